// File: rtl/egcd_pkg.sv
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types and constants for the 64-bit extended gcd block.
// ----------------------------------------------------------------------------
package egcd_pkg;

   localparam int DATA_W = 64;
   localparam int CNT_W  = $clog2(DATA_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   // control from the sequencer to the divide unit
   typedef struct packed {
      logic start;
   } div_ctl_type;

   // status from the divide unit back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// File: rtl/egcd_divstep.sv
// ----------------------------------------------------------------------------
// egcd_divstep
// Radix-2 restoring divider, one quotient bit per cycle. Alongside the
// division it forms q*mult_b and q*mult_s (mod 2^64) by Horner's rule on
// the quotient bits as they come out, MSB first.
// ----------------------------------------------------------------------------
module egcd_divstep (
   input  logic                              clock,
   input  logic                              reset,
   input  egcd_pkg::div_ctl_type             div_ctl,
   input  logic [egcd_pkg::DATA_W-1:0]       dividend,
   input  logic [egcd_pkg::DATA_W-1:0]       divisor,
   input  logic [egcd_pkg::DATA_W-1:0]       mult_b,
   input  logic [egcd_pkg::DATA_W-1:0]       mult_s,
   output egcd_pkg::div_sts_type             div_sts,
   output logic [egcd_pkg::DATA_W-1:0]       rem_out,
   output logic [egcd_pkg::DATA_W-1:0]       prod_b,
   output logic [egcd_pkg::DATA_W-1:0]       prod_s
);

   logic [egcd_pkg::DATA_W-1:0] dvd_ff, dvd_in;
   logic [egcd_pkg::DATA_W-1:0] rem_ff, rem_in;
   logic [egcd_pkg::DATA_W-1:0] dsr_ff, dsr_in;
   logic [egcd_pkg::DATA_W-1:0] mb_ff, mb_in;
   logic [egcd_pkg::DATA_W-1:0] ms_ff, ms_in;
   logic [egcd_pkg::DATA_W-1:0] accb_ff, accb_in;
   logic [egcd_pkg::DATA_W-1:0] accs_ff, accs_in;
   logic [egcd_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;

   logic [egcd_pkg::DATA_W:0]   rem_sh;
   logic [egcd_pkg::DATA_W:0]   dsr_ext;
   logic                        q_bit;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[egcd_pkg::DATA_W-1]};
      dsr_ext = {1'b0, dsr_ff};
      q_bit   = (rem_sh >= dsr_ext);

      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      mb_in   = mb_ff;
      ms_in   = ms_ff;
      accb_in = accb_ff;
      accs_in = accs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (div_ctl.start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         mb_in   = mult_b;
         ms_in   = mult_s;
         accb_in = '0;
         accs_in = '0;
         cnt_in  = '1;
         run_in  = 1'b1;
      end else if (run_ff) begin
         dvd_in  = {dvd_ff[egcd_pkg::DATA_W-2:0], 1'b0};
         rem_in  = q_bit ? (rem_sh[egcd_pkg::DATA_W-1:0] - dsr_ff)
                         : rem_sh[egcd_pkg::DATA_W-1:0];
         accb_in = {accb_ff[egcd_pkg::DATA_W-2:0], 1'b0} + (q_bit ? mb_ff : '0);
         accs_in = {accs_ff[egcd_pkg::DATA_W-2:0], 1'b0} + (q_bit ? ms_ff : '0);
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      mb_ff   <= mb_in;
      ms_ff   <= ms_in;
      accb_ff <= accb_in;
      accs_ff <= accs_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign div_sts.busy = run_ff;
   assign div_sts.done = done_ff;
   assign rem_out      = rem_ff;
   assign prod_b       = accb_ff;
   assign prod_s       = accs_ff;

endmodule

// File: rtl/extended_gcd_64.sv
// ----------------------------------------------------------------------------
// extended_gcd_64
// Extended Euclid on two unsigned 64-bit operands: gcd and Bezout pair.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries alpha and beta. The block
//   takes one request at a time; req_stall is high from acceptance until the
//   result has been moved into the output register.
//   Result channel (rsp_valid/rsp_stall) carries gcd and the signed
//   coefficients with coef_alpha*alpha + coef_beta*beta == gcd.
//   Path to rsp_valid: a zero operand goes straight to ST_DONE and from there
//   into the output register. Otherwise each Euclid quotient step is one pass
//   of the shared bit-serial divider (load, 64 quotient bits), and the result
//   then goes through ST_DONE into the output register; the number of steps,
//   and so the latency, depends on the operands.
//   The next request can be accepted while the previous result still waits
//   in the output register.
//   Stall: a held result stays stable; a finished computation waits for the
//   output register to free up.
//   Reset: synchronous, active high; clears the sequencer and drops rsp_valid.
// ----------------------------------------------------------------------------
module extended_gcd_64 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [egcd_pkg::DATA_W-1:0] req_alpha_value,
   input  logic [egcd_pkg::DATA_W-1:0] req_beta_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [egcd_pkg::DATA_W-1:0] rsp_gcd_value,
   output logic signed [egcd_pkg::DATA_W-1:0] rsp_coef_alpha,
   output logic signed [egcd_pkg::DATA_W-1:0] rsp_coef_beta
);

   egcd_pkg::state_type state_ff, state_in;

   logic [egcd_pkg::DATA_W-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [egcd_pkg::DATA_W-1:0] sb0_ff, sb0_in, ss0_ff, ss0_in;
   logic [egcd_pkg::DATA_W-1:0] sb1_ff, sb1_in, ss1_ff, ss1_in;
   logic                        swap_ff, swap_in;
   logic [egcd_pkg::DATA_W-1:0] res_g_ff, res_g_in;
   logic [egcd_pkg::DATA_W-1:0] res_a_ff, res_a_in;
   logic [egcd_pkg::DATA_W-1:0] res_b_ff, res_b_in;
   logic [egcd_pkg::DATA_W-1:0] out_g_ff, out_g_in;
   logic [egcd_pkg::DATA_W-1:0] out_a_ff, out_a_in;
   logic [egcd_pkg::DATA_W-1:0] out_b_ff, out_b_in;
   logic                        out_vld_ff, out_vld_in;

   egcd_pkg::div_ctl_type       div_ctl;
   egcd_pkg::div_sts_type       div_sts;
   logic [egcd_pkg::DATA_W-1:0] div_rem, div_pb, div_ps;
   logic                        req_take;
   logic                        rsp_take;

   egcd_divstep u_divstep (
      .clock    (clock),
      .reset    (reset),
      .div_ctl  (div_ctl),
      .dividend (r0_in),
      .divisor  (r1_in),
      .mult_b   (sb1_in),
      .mult_s   (ss1_in),
      .div_sts  (div_sts),
      .rem_out  (div_rem),
      .prod_b   (div_pb),
      .prod_s   (div_ps)
   );

   assign req_stall = (state_ff != egcd_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_vld_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= egcd_pkg::ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      sb0_ff   <= sb0_in;
      ss0_ff   <= ss0_in;
      sb1_ff   <= sb1_in;
      ss1_ff   <= ss1_in;
      swap_ff  <= swap_in;
      res_g_ff <= res_g_in;
      res_a_ff <= res_a_in;
      res_b_ff <= res_b_in;
      out_g_ff <= out_g_in;
      out_a_ff <= out_a_in;
      out_b_ff <= out_b_in;
   end

   always_comb begin
      state_in      = state_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      sb0_in        = sb0_ff;
      ss0_in        = ss0_ff;
      sb1_in        = sb1_ff;
      ss1_in        = ss1_ff;
      swap_in       = swap_ff;
      res_g_in      = res_g_ff;
      res_a_in      = res_a_ff;
      res_b_in      = res_b_ff;
      out_g_in      = out_g_ff;
      out_a_in      = out_a_ff;
      out_b_in      = out_b_ff;
      out_vld_in    = out_vld_ff && !rsp_take;
      div_ctl.start = 1'b0;

      case (state_ff)
         egcd_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_alpha_value == '0) begin
                  res_g_in = req_beta_value;
                  res_a_in = '0;
                  res_b_in = egcd_pkg::DATA_W'(1);
                  state_in = egcd_pkg::ST_DONE;
               end else if (req_beta_value == '0) begin
                  res_g_in = req_alpha_value;
                  res_a_in = egcd_pkg::DATA_W'(1);
                  res_b_in = '0;
                  state_in = egcd_pkg::ST_DONE;
               end else begin
                  // reduce the larger operand by the smaller
                  swap_in       = (req_alpha_value < req_beta_value);
                  r0_in         = swap_in ? req_beta_value : req_alpha_value;
                  r1_in         = swap_in ? req_alpha_value : req_beta_value;
                  sb0_in        = egcd_pkg::DATA_W'(1);
                  ss0_in        = '0;
                  sb1_in        = '0;
                  ss1_in        = egcd_pkg::DATA_W'(1);
                  div_ctl.start = 1'b1;
                  state_in      = egcd_pkg::ST_DIV;
               end
            end
         end
         egcd_pkg::ST_DIV: begin
            if (div_sts.done) begin
               if (div_rem == '0) begin
                  res_g_in = r1_ff;
                  res_a_in = swap_ff ? ss1_ff : sb1_ff;
                  res_b_in = swap_ff ? sb1_ff : ss1_ff;
                  state_in = egcd_pkg::ST_DONE;
               end else begin
                  r0_in         = r1_ff;
                  r1_in         = div_rem;
                  sb0_in        = sb1_ff;
                  ss0_in        = ss1_ff;
                  sb1_in        = sb0_ff - div_pb;
                  ss1_in        = ss0_ff - div_ps;
                  div_ctl.start = 1'b1;
               end
            end
         end
         egcd_pkg::ST_DONE: begin
            if (!out_vld_ff || rsp_take) begin
               out_g_in   = res_g_ff;
               out_a_in   = res_a_ff;
               out_b_in   = res_b_ff;
               out_vld_in = 1'b1;
               state_in   = egcd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = egcd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_gcd_value  = out_g_ff;
   assign rsp_coef_alpha = out_a_ff;
   assign rsp_coef_beta  = out_b_ff;

   // divider finishes only while the sequencer waits on it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == egcd_pkg::ST_DIV))
      else $error("divider done outside ST_DIV");

   // no division by zero
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == egcd_pkg::ST_DIV) |-> (r1_ff != '0))
      else $error("zero divisor in ST_DIV");

   // remainder must come back below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (div_rem < r1_ff))
      else $error("remainder not below divisor");

   // divider is running whenever a step is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == egcd_pkg::ST_DIV) && !div_sts.done) |-> div_sts.busy)
      else $error("ST_DIV with idle divider");

   // held result does not move while stalled
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && rsp_stall) |=> (out_vld_ff && $stable(out_g_ff)))
      else $error("stalled result changed");

endmodule

// File: dv/tb_extended_gcd_64.sv
// ----------------------------------------------------------------------------
// tb_extended_gcd_64
// Self-checking bench for the 64-bit extended gcd block. A queue-fed driver
// offers operand pairs. A clocked monitor compares each result field by
// field against a local extended Euclid predictor. Both sides idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_extended_gcd_64;

   localparam int IDLE_PCT    = 22;
   localparam int HOLD_AT     = 20;     // results seen before the long hold-off
   localparam int HOLD_CYCLES = 20000;  // longer than two worst-case requests
   localparam int QUIET_LO    = 40;     // no idling on either side in this window
   localparam int QUIET_HI    = 70;
   localparam int N_RANDOM    = 80;

   typedef logic [egcd_pkg::DATA_W-1:0] word_type;

   typedef struct packed {
      word_type alpha;
      word_type beta;
   } operand_pair_type;

   typedef struct packed {
      word_type                           gcd;
      logic signed [egcd_pkg::DATA_W-1:0] coef_alpha;
      logic signed [egcd_pkg::DATA_W-1:0] coef_beta;
   } bezout_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   word_type req_alpha_value = '0;
   word_type req_beta_value = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_gcd_value;
   logic signed [egcd_pkg::DATA_W-1:0] rsp_coef_alpha;
   logic signed [egcd_pkg::DATA_W-1:0] rsp_coef_beta;

   operand_pair_type operand_q[$];
   bezout_type       bezout_q[$];
   operand_pair_type next_pair;
   bezout_type       want;
   int               n_sent = 0;
   int               n_rcvd = 0;
   int               hold_left = 0;
   int               err_cnt = 0;

   extended_gcd_64 i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_alpha_value(req_alpha_value),
      .req_beta_value (req_beta_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gcd_value  (rsp_gcd_value),
      .rsp_coef_alpha (rsp_coef_alpha),
      .rsp_coef_beta  (rsp_coef_beta)
   );

   always #5 clock = ~clock;

   // Extended Euclid, coefficients kept modulo 2^64. The larger operand is
   // reduced by the smaller; the pair is swapped back when alpha was smaller.
   function automatic bezout_type bezout_of(word_type a, word_type b);
      word_type   r0, r1, s0, t0, s1, t1, q, rem, ns, nt;
      logic       swapped;
      bezout_type res;
      if (a == '0) begin
         res = '{gcd: b, coef_alpha: '0, coef_beta: 64'd1};
      end else if (b == '0) begin
         res = '{gcd: a, coef_alpha: 64'd1, coef_beta: '0};
      end else begin
         swapped = (a < b);
         r0 = swapped ? b : a;
         r1 = swapped ? a : b;
         s0 = 64'd1; t0 = '0;
         s1 = '0;    t1 = 64'd1;
         while (1) begin
            q   = r0 / r1;
            rem = r0 - q * r1;
            if (rem == '0) break;
            ns = s0 - q * s1;
            nt = t0 - q * t1;
            r0 = r1;  s0 = s1; t0 = t1;
            r1 = rem; s1 = ns; t1 = nt;
         end
         res.gcd        = r1;
         res.coef_alpha = swapped ? t1 : s1;
         res.coef_beta  = swapped ? s1 : t1;
      end
      return res;
   endfunction

   function automatic word_type rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic void add_pair(word_type a, word_type b);
      operand_q.push_back(operand_pair_type'{alpha: a, beta: b});
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            bezout_q.push_back(bezout_of(req_alpha_value, req_beta_value));
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (operand_q.size() > 0 &&
                ((n_sent >= QUIET_LO && n_sent < QUIET_HI) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               next_pair = operand_q.pop_front();
               req_valid       <= 1'b1;
               req_alpha_value <= next_pair.alpha;
               req_beta_value  <= next_pair.beta;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_rcvd++;
            if (bezout_q.size() == 0) begin
               $error("result with no request outstanding: gcd_value %h", rsp_gcd_value);
               err_cnt++;
            end else begin
               want = bezout_q.pop_front();
               if (rsp_gcd_value !== want.gcd) begin
                  $error("gcd_value: expected %0d, actual %0d", want.gcd, rsp_gcd_value);
                  err_cnt++;
               end
               if (rsp_coef_alpha !== want.coef_alpha) begin
                  $error("coef_alpha: expected %0d, actual %0d",
                         $signed(want.coef_alpha), rsp_coef_alpha);
                  err_cnt++;
               end
               if (rsp_coef_beta !== want.coef_beta) begin
                  $error("coef_beta: expected %0d, actual %0d",
                         $signed(want.coef_beta), rsp_coef_beta);
                  err_cnt++;
               end
            end
            if (n_rcvd == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !(n_rcvd >= QUIET_LO && n_rcvd < QUIET_HI) &&
                         ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   initial begin
      word_type all1, fib_lo, fib_hi, tmp, g, a, b;
      int       shift;
      all1 = '1;
      // consecutive Fibonacci numbers give the longest Euclid chain
      fib_lo = 64'd1;
      fib_hi = 64'd1;
      repeat (91) begin
         tmp    = fib_hi;
         fib_hi = fib_hi + fib_lo;
         fib_lo = tmp;
      end

      // directed: zero operands, equal operands, extremes, both orderings
      add_pair('0, '0);
      add_pair('0, all1);
      add_pair(all1, '0);
      add_pair('0, 64'd1);
      add_pair(64'd1, '0);
      add_pair(all1, all1);
      add_pair(64'd1, 64'd1);
      add_pair(all1, 64'd1);
      add_pair(64'd1, all1);
      add_pair(all1, all1 - 1);
      add_pair(all1 - 1, all1);
      add_pair(fib_hi, fib_lo);
      add_pair(fib_lo, fib_hi);
      add_pair(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
      add_pair(64'h8000_0000_0000_0000, 64'd3);
      add_pair(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
      add_pair(64'd240, 64'd46);
      add_pair(64'd12, 64'd18);
      add_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      add_pair(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FF43);

      for (int i = 0; i < N_RANDOM; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               a = rand_word();
               b = rand_word();
            end
            4: begin
               shift = $urandom_range(63);
               a = rand_word();
               b = rand_word() >> shift;
               if ($urandom_range(1)) begin
                  tmp = a; a = b; b = tmp;
               end
            end
            5: begin
               // shared factor, no overflow
               g = word_type'($urandom_range(1, 1 << 20));
               a = g * (rand_word() >> 24);
               b = g * (rand_word() >> 24);
            end
            6: begin
               a = word_type'($urandom_range(1000));
               b = word_type'($urandom_range(1000));
            end
            7: begin
               a = rand_word();
               b = '0;
               if ($urandom_range(1)) begin
                  b = a; a = '0;
               end
            end
            8: begin
               a = rand_word();
               b = a;
            end
            default: begin
               a = rand_word() | 64'h8000_0000_0000_0000;
               b = a - word_type'($urandom_range(1, 1000));
            end
         endcase
         add_pair(a, b);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (operand_q.size() > 0 || req_valid) @(negedge clock);
      while (bezout_q.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);

      if (err_cnt == 0 && bezout_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: files.f
rtl/egcd_pkg.sv
rtl/egcd_divstep.sv
rtl/extended_gcd_64.sv
dv/tb_extended_gcd_64.sv
